>>> sv/aldf_pkg.sv
package aldf_pkg;

  localparam int DEPTH_DEF = 8;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;

  localparam logic [ACT_W-1:0] ACT_FIND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INS  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEL  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

>>> sv/aldf_mem.sv
module aldf_mem #(
  parameter int DEPTH = aldf_pkg::DEPTH_DEF,
  parameter int AW    = 3
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [aldf_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [aldf_pkg::VALUE_W-1:0] rdata
);

  logic [aldf_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/array_list_insert_delete_find.sv
// find: empty list answered from idle; else each entry scanned is read, then compared
// insert/delete: each moved entry is read, then written; insert then adds the value
// rejected or unused requests never raise busy; a result shows when busy drops
// one word at a time, busy meanwhile; the next word is taken while the result shows
// reset clears the entry count and the result strobe; list memory is not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
module array_list_insert_delete_find #(
  parameter int DEPTH = aldf_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [aldf_pkg::ACT_W-1:0]          in_action,
  input  logic signed [aldf_pkg::VALUE_W-1:0] in_item_value,
  input  logic [aldf_pkg::POS_W-1:0]          in_item_position,
  output logic                                out_valid,
  output logic [aldf_pkg::STAT_W-1:0]         out_status,
  output logic [aldf_pkg::IDX_W-1:0]          out_found_index,
  output logic [aldf_pkg::CNT_W-1:0]          out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MRD  = 6'b000010,
    S_MWR  = 6'b000100,
    S_NEW  = 6'b001000,
    S_FRD  = 6'b010000,
    S_FCMP = 6'b100000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [aldf_pkg::ACT_W-1:0]            op_r, op_nxt;
  logic signed [aldf_pkg::VALUE_W-1:0]   val_r, val_nxt;
  logic [CW-1:0]                         pos_r, pos_nxt;
  logic [CW-1:0]                         idx_r, idx_nxt;
  logic [CW-1:0]                         cnt_r, cnt_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [aldf_pkg::STAT_W-1:0]           out_status_r, out_status_nxt;
  logic [aldf_pkg::IDX_W-1:0]            out_found_index_r, out_found_index_nxt;
  logic [aldf_pkg::CNT_W-1:0]            out_entry_count_r;

  logic [CW-1:0]                         idx_inc, idx_dec;
  logic                                  mem_we;
  logic [AW-1:0]                         mem_waddr, mem_raddr;
  logic [aldf_pkg::VALUE_W-1:0]          mem_wdata, mem_rdata;

  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);

  aldf_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt           = state_r;
    op_nxt              = op_r;
    val_nxt             = val_r;
    pos_nxt             = pos_r;
    idx_nxt             = idx_r;
    cnt_nxt             = cnt_r;
    out_valid_nxt       = 1'b0;
    out_status_nxt      = aldf_pkg::ST_OK;
    out_found_index_nxt = '0;
    mem_we              = 1'b0;
    mem_waddr           = idx_r[AW-1:0];
    mem_wdata           = mem_rdata;
    mem_raddr           = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_action;
          val_nxt = in_item_value;
          pos_nxt = CW'(in_item_position);
          unique case (in_action)
            aldf_pkg::ACT_FIND: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = aldf_pkg::ST_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_FRD;
              end
            end
            aldf_pkg::ACT_INS: begin
              if (cnt_r == CW'(DEPTH)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = aldf_pkg::ST_FULL;
              end else if (in_item_position > aldf_pkg::POS_W'(cnt_r)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = aldf_pkg::ST_BADPOS;
              end else begin
                idx_nxt = cnt_r;
                if (aldf_pkg::POS_W'(cnt_r) == in_item_position) begin
                  state_nxt = S_NEW;
                end else begin
                  state_nxt = S_MRD;
                end
              end
            end
            aldf_pkg::ACT_DEL: begin
              if (in_item_position >= aldf_pkg::POS_W'(cnt_r)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = aldf_pkg::ST_BADPOS;
              end else begin
                idx_nxt = CW'(in_item_position);
                if (aldf_pkg::POS_W'(cnt_r) == in_item_position + aldf_pkg::POS_W'(1)) begin
                  cnt_nxt       = cnt_r - CW'(1);
                  out_valid_nxt = 1'b1;
                end else begin
                  state_nxt = S_MRD;
                end
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_MRD: begin
        if (op_r == aldf_pkg::ACT_INS) begin
          mem_raddr = idx_dec[AW-1:0];
        end else begin
          mem_raddr = idx_inc[AW-1:0];
        end
        state_nxt = S_MWR;
      end
      S_MWR: begin
        mem_we = 1'b1;
        if (op_r == aldf_pkg::ACT_INS) begin
          idx_nxt = idx_dec;
          if (idx_dec == pos_r) begin
            state_nxt = S_NEW;
          end else begin
            state_nxt = S_MRD;
          end
        end else begin
          idx_nxt = idx_inc;
          if (idx_inc + CW'(1) == cnt_r) begin
            cnt_nxt       = cnt_r - CW'(1);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_MRD;
          end
        end
      end
      S_NEW: begin
        mem_we        = 1'b1;
        mem_waddr     = pos_r[AW-1:0];
        mem_wdata     = val_r;
        cnt_nxt       = cnt_r + CW'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FRD: begin
        state_nxt = S_FCMP;
      end
      S_FCMP: begin
        if (mem_rdata == val_r) begin
          out_valid_nxt       = 1'b1;
          out_found_index_nxt = aldf_pkg::IDX_W'(idx_r);
          state_nxt           = S_IDLE;
        end else if (idx_inc == cnt_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = aldf_pkg::ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_FRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r              <= op_nxt;
    val_r             <= val_nxt;
    pos_r             <= pos_nxt;
    idx_r             <= idx_nxt;
    out_status_r      <= out_status_nxt;
    out_found_index_r <= out_found_index_nxt;
    out_entry_count_r <= aldf_pkg::CNT_W'(cnt_nxt);
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_index_r;
  assign out_entry_count = out_entry_count_r;

endmodule

>>> sim/aldf_checker.sv
module aldf_checker
  import aldf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [ACT_W-1:0]          in_action,
  input  logic signed [VALUE_W-1:0] in_item_value,
  input  logic [POS_W-1:0]          in_item_position,
  input  logic                      out_valid,
  input  logic [STAT_W-1:0]         out_status,
  input  logic [IDX_W-1:0]          out_found_index,
  input  logic [CNT_W-1:0]          out_entry_count,
  output int                        mismatches,
  output int                        pending,
  output int                        fill,
  output int                        words_checked,
  output int                        finds_hit,
  output int                        full_refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index;
    logic [CNT_W-1:0]  count;
  } reply_t;

  logic [VALUE_W-1:0] list_vals [DEPTH];
  int                 list_count = 0;
  reply_t             expected_replies [$];
  int                 n_bad = 0;
  int                 n_checked = 0;
  int                 n_hit = 0;
  int                 n_full = 0;

  assign mismatches    = n_bad;
  assign pending       = expected_replies.size();
  assign fill          = list_count;
  assign words_checked = n_checked;
  assign finds_hit     = n_hit;
  assign full_refusals = n_full;

  // updates the shadow list and returns the reply the block owes
  function automatic reply_t apply_request(logic [ACT_W-1:0] act, logic [VALUE_W-1:0] val,
                                           logic [POS_W-1:0] pos);
    reply_t r;
    int     i;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = list_count - 1; i >= 0; i--) begin
          if (list_vals[i] == val) begin
            r.status = ST_OK;
            r.index  = i[IDX_W-1:0];
          end
        end
        if (r.status == ST_OK) n_hit++;
      end
      ACT_INS: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else if (pos > list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = list_count; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_count++;
        end
      end
      ACT_DEL: begin
        if (pos >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = pos; i + 1 < list_count; i++) list_vals[i] = list_vals[i+1];
          list_count--;
        end
      end
      default: ;
    endcase
    r.count = list_count[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst_n) begin
      if (out_valid) begin
        got = '{status: out_status, index: out_found_index, count: out_entry_count};
        n_checked++;
        if (expected_replies.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: unexpected word: status %0d index %0d count %0d", $time,
                     got.status, got.index, got.count);
        end else begin
          want = expected_replies.pop_front();
          if (want != got) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: mismatch on reply word", $time);
              if (want.status != got.status)
                $display("  status: expected %0d, got %0d", want.status, got.status);
              if (want.index != got.index)
                $display("  found_index: expected %0d, got %0d", want.index, got.index);
              if (want.count != got.count)
                $display("  entry_count: expected %0d, got %0d", want.count, got.count);
            end
          end
        end
      end
      if (start && !busy)
        expected_replies.push_back(apply_request(in_action, in_item_value, in_item_position));
    end
  end

endmodule

>>> sim/array_list_insert_delete_find_tb.sv
module array_list_insert_delete_find_tb;
  import aldf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_TAIL = 150;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [ACT_W-1:0]          in_action = ACT_FIND;
  logic signed [VALUE_W-1:0] in_item_value = '0;
  logic [POS_W-1:0]          in_item_position = '0;
  logic                      out_valid;
  logic [STAT_W-1:0]         out_status;
  logic [IDX_W-1:0]          out_found_index;
  logic [CNT_W-1:0]          out_entry_count;

  int mismatches, pending, fill, words_checked, finds_hit, full_refusals;
  int n_sent = 0;

  logic [VALUE_W-1:0] value_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                         32'h7FFF_FFFF, 32'h5A5A_5A5A, 32'h1234_5678};

  array_list_insert_delete_find #(.DEPTH(DEPTH)) uut (.*);

  aldf_checker #(.DEPTH(DEPTH)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send(input logic [ACT_W-1:0] act, input logic [VALUE_W-1:0] val,
                      input logic [POS_W-1:0] pos);
    @(negedge clk);
    start            <= 1'b1;
    in_action        <= act;
    in_item_value    <= val;
    in_item_position <= pos;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  task automatic idle(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    idle(1);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return value_pool[$urandom_range(0, 5)];
  endfunction

  initial begin
    int                 k;
    int                 r;
    logic [ACT_W-1:0]   act;
    logic [POS_W-1:0]   pos;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list
    send(ACT_FIND, 32'h0000_0000, 8'd0);
    send(ACT_DEL, 32'h0000_0000, 8'd0);
    send(ACT_DEL, 32'hFFFF_FFFF, 8'd255);
    send(ACT_INS, 32'h1111_1111, 8'd1);
    send(ACT_INS, 32'h2222_2222, 8'd255);
    // fill at head, tail and middle, with duplicates
    send(ACT_INS, 32'h8000_0000, 8'd0);
    send(ACT_INS, 32'h7FFF_FFFF, 8'd1);
    send(ACT_INS, 32'h0000_0000, 8'd1);
    send(ACT_INS, 32'hFFFF_FFFF, 8'd0);
    send(ACT_INS, 32'h7FFF_FFFF, 8'd4);
    send(ACT_INS, 32'h5555_5555, 8'd2);
    send(ACT_INS, 32'hAAAA_AAAA, 8'd6);
    send(ACT_INS, 32'h7FFF_FFFF, 8'd3);
    // full list, fullness wins over a bad position
    send(ACT_INS, 32'h0F0F_0F0F, 8'd0);
    send(ACT_INS, 32'hF0F0_F0F0, 8'd255);
    send(ACT_FIND, 32'h7FFF_FFFF, 8'd0);
    send(ACT_FIND, 32'h8000_0000, 8'd255);
    send(ACT_FIND, 32'h1234_5678, 8'd0);
    send(ACT_SPARE, 32'hFFFF_FFFF, 8'd255);
    send(ACT_DEL, 32'h0000_0000, 8'd8);
    send(ACT_DEL, 32'h0000_0000, 8'd7);
    send(ACT_DEL, 32'h0000_0000, 8'd0);
    send(ACT_DEL, 32'h0000_0000, 8'd3);
    send(ACT_FIND, 32'h7FFF_FFFF, 8'd0);
    drain();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 5) act = ACT_SPARE;
      else if (r < 35) act = ACT_FIND;
      else if (r < (((k / 100) % 2) ? 75 : 55)) act = ACT_INS;
      else act = ACT_DEL;

      if ($urandom_range(0, 9) < 2) pos = $urandom_range(0, 255);
      else if (act == ACT_INS) pos = $urandom_range(0, fill);
      else if (fill > 0) pos = $urandom_range(0, fill - 1);
      else pos = $urandom_range(0, 255);

      send(act, pick_value(), pos);

      if (k < RANDOM_ITEMS - QUIET_TAIL) begin
        if (k % 200 == 199) drain();
        else if ($urandom_range(0, 4) == 0) idle($urandom_range(1, 16));
      end
    end
    idle(1);

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("summary: %0d requests driven, %0d reply words checked", n_sent, words_checked);
    $display("summary: %0d finds matched, %0d inserts refused on a full list",
             finds_hit, full_refusals);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
